// ----- src/prns_pkg.sv -----
// Package for the population rate network step block.
// Shared types, constants and fixed-point helpers; no dependencies.
package prns_pkg;

  localparam int unsigned POPULATIONS = 4;
  localparam int unsigned IDX_W = 2;

  localparam int unsigned RATE_W = 31;
  localparam int unsigned SUM_W = 47;
  // four weighted terms of up to 2^46 plus the drive
  localparam int unsigned ACC_W = 50;

  localparam logic [1:0] KIND_PAIR = 2'd0;
  localparam logic [1:0] KIND_POP = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [0:0] REG_START = 1'b0;
  localparam logic [0:0] REG_WINDOW = 1'b1;

  localparam logic WHAT_RATE = 1'b0;
  localparam logic WHAT_SUM = 1'b1;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_DECAY = 2'd0,
    MUL_GAIN = 2'd1,
    MUL_RK = 2'd2,
    MUL_WEIGHT = 2'd3
  } mul_op_t;

  // controller -> datapath
  typedef struct packed {
    logic load_pair;
    logic load_pop;
    logic begin_pop;
    logic mul_en;
    mul_op_t mul_op;
    logic acc_en;
    logic syn_write;
    logic add_weighted;
    logic rate_write;
    logic rate_commit;
    logic sum_add;
    logic sum_clear;
    logic out_load;
    logic out_what;
    logic out_last;
  } prns_cmd_t;

  // round a product that has 16 extra fraction bits, half toward +inf
  function automatic logic signed [49:0] round16(input logic signed [65:0] p);
    logic signed [65:0] t;
    begin
      t = p + 66'sd32768;
      round16 = t[65:16];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    begin
      if (v > 51'sd2147483647) sat32 = 32'sh7FFFFFFF;
      else if (v < -51'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- src/prns_datapath.sv -----
// Datapath for the population rate network step: coefficient and state
// storage, one shared multiplier, accumulators and the result register.
// Depends on prns_pkg.
module prns_datapath import prns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  prns_cmd_t cmd,
  input  logic [IDX_W-1:0] row,
  input  logic [IDX_W-1:0] col,
  input  logic signed [31:0] weight,
  input  logic [16:0] decay,
  input  logic [16:0] gain,
  input  logic [16:0] rk_factor,
  input  logic signed [31:0] syn_init,
  input  logic signed [31:0] drive,
  input  logic [RATE_W-1:0] rate_init,
  output logic pair_on,
  output logic [IDX_W-1:0] out_population,
  output logic out_what,
  output logic [SUM_W-1:0] out_value,
  output logic out_last
);

  localparam int unsigned PAIRS = POPULATIONS * POPULATIONS;
  localparam int unsigned PW = 2 * IDX_W;

  logic signed [31:0] syn [PAIRS];
  logic signed [31:0] wgt [PAIRS];
  logic [16:0] dcy [PAIRS];
  logic [16:0] gn [PAIRS];
  logic [16:0] rkf [PAIRS];
  logic signed [31:0] drv [POPULATIONS];
  logic [RATE_W-1:0] rate [POPULATIONS];
  logic [RATE_W-1:0] rate_new [POPULATIONS];
  logic [SUM_W-1:0] wsum [POPULATIONS];

  logic [PW-1:0] pidx;
  logic [IDX_W-1:0] ri, ci;
  logic signed [65:0] prod;
  logic signed [50:0] acc;
  logic signed [31:0] s1;
  logic signed [ACC_W-1:0] inp;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] prod_r;
  logic signed [32:0] rj;
  logic signed [ACC_W-1:0] inp_clip;
  logic [SUM_W:0] sum_ext;

  assign ri = row;
  assign ci = col;
  assign pidx = {row, col};
  assign pair_on = (wgt[pidx] != 32'sd0);
  assign rj = {2'b00, rate[ci]};
  assign prod_r = round16(prod);

  always_comb begin
    mul_a = {1'b0, 32'd0};
    mul_b = {syn[pidx][31], syn[pidx]};
    case (cmd.mul_op)
      MUL_DECAY: begin
        mul_a = {16'd0, dcy[pidx]};
        mul_b = {syn[pidx][31], syn[pidx]};
      end
      MUL_GAIN: begin
        mul_a = {16'd0, gn[pidx]};
        mul_b = rj;
      end
      MUL_RK: begin
        mul_a = {16'd0, rkf[pidx]};
        mul_b = rj - {s1[31], s1};
      end
      MUL_WEIGHT: begin
        mul_a = {wgt[pidx][31], wgt[pidx]};
        mul_b = {s1[31], s1};
      end
      default: ;
    endcase
  end

  always_comb begin
    if (inp < 0) inp_clip = '0;
    else if (inp > ACC_W'(64'h7FFFFFFF)) inp_clip = ACC_W'(64'h7FFFFFFF);
    else inp_clip = inp;
    // window sums take the rate of this tick
    sum_ext = {1'b0, wsum[ri]} + (SUM_W + 1)'(rate_new[ri]);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= mul_a * mul_b;
    case (cmd.mul_op)
      MUL_DECAY: if (cmd.acc_en) acc <= 51'(prod_r);
      MUL_GAIN: if (cmd.acc_en) s1 <= sat32(acc + 51'(prod_r));
      MUL_RK: if (cmd.acc_en) s1 <= sat32({{19{s1[31]}}, s1} + 51'(prod_r));
      default: ;
    endcase
    if (cmd.begin_pop) inp <= ACC_W'(drv[ri]);
    else if (cmd.add_weighted) inp <= inp + ACC_W'(prod_r);
    if (cmd.rate_write) rate_new[ri] <= inp_clip[RATE_W-1:0];
    if (cmd.out_load) begin
      out_population <= ri;
      out_what <= cmd.out_what;
      out_last <= cmd.out_last;
      out_value <= cmd.out_what ? wsum[ri] : SUM_W'(rate_new[ri]);
    end
    if (rst) begin
      for (int k = 0; k < PAIRS; k++) begin
        syn[k] <= '0;
        wgt[k] <= '0;
        dcy[k] <= '0;
        gn[k] <= '0;
        rkf[k] <= '0;
      end
      for (int k = 0; k < POPULATIONS; k++) begin
        drv[k] <= '0;
        rate[k] <= '0;
        wsum[k] <= '0;
      end
    end else begin
      if (cmd.syn_write) syn[pidx] <= s1;
      else if (cmd.load_pair) begin
        wgt[pidx] <= weight;
        dcy[pidx] <= decay;
        gn[pidx] <= gain;
        rkf[pidx] <= rk_factor;
        syn[pidx] <= syn_init;
      end
      if (cmd.load_pop) begin
        drv[ri] <= drive;
        rate[ri] <= rate_init;
      end else if (cmd.rate_commit) begin
        // commit new rates population by population after the whole sweep
        rate[ri] <= rate_new[ri];
      end
      if (cmd.sum_add) wsum[ri] <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      else if (cmd.sum_clear) wsum[ri] <= '0;
    end
  end

endmodule

// ----- src/prns_ctrl.sv -----
// Controller for the population rate network step: walks pairs and
// populations, sequences the shared multiplier and the result transfers.
// Depends on prns_pkg.
module prns_ctrl import prns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [IDX_W-1:0] row_in,
  input  logic [IDX_W-1:0] col_in,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic pair_on,
  output prns_cmd_t cmd,
  output logic [IDX_W-1:0] row,
  output logic [IDX_W-1:0] col,
  output logic out_valid,
  input  logic out_stall
);

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_PAIR, S_M1, S_M2, S_M3, S_M4, S_NEXT,
    S_WAIT, S_ADD, S_DONE, S_COMMIT, S_EMIT, S_WIN
  } state_t;

  state_t state;
  logic [31:0] start_ticks, window_ticks, tick_count, window_count;
  logic started, win_due;
  logic [IDX_W-1:0] ri, ci;
  logic pop_ok, pair_ok, accept;
  logic out_free;
  logic [IDX_W:0] pops_c;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POPULATIONS - 1);

  assign pops_c = (IDX_W + 1)'(POPULATIONS);
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pop_ok = {1'b0, row_in} < pops_c;
  assign pair_ok = pop_ok && ({1'b0, col_in} < pops_c);
  assign row = (state == S_IDLE) ? row_in : ri;
  assign col = (state == S_IDLE) ? col_in : ci;

  always_comb begin
    cmd = '0;
    cmd.mul_op = MUL_DECAY;
    case (state)
      S_IDLE: begin
        cmd.load_pair = accept && kind == KIND_PAIR && pair_ok;
        cmd.load_pop = accept && kind == KIND_POP && pop_ok;
      end
      S_POP: cmd.begin_pop = 1'b1;
      S_PAIR: begin
        cmd.mul_en = pair_on;
        cmd.mul_op = MUL_DECAY;
      end
      S_M1: begin
        cmd.mul_op = MUL_DECAY;
        cmd.acc_en = 1'b1;
      end
      S_M2: begin
        cmd.mul_op = MUL_GAIN;
        cmd.mul_en = 1'b1;
      end
      S_M3: begin
        cmd.mul_op = MUL_GAIN;
        cmd.acc_en = 1'b1;
      end
      S_M4: begin
        cmd.mul_op = MUL_RK;
        cmd.mul_en = 1'b1;
      end
      S_NEXT: begin
        cmd.mul_op = MUL_RK;
        cmd.acc_en = 1'b1;
      end
      S_WAIT: begin
        cmd.mul_op = MUL_WEIGHT;
        cmd.mul_en = 1'b1;
        cmd.syn_write = 1'b1;
      end
      S_ADD: cmd.add_weighted = 1'b1;
      S_DONE: cmd.rate_write = (ci == LAST_IDX);
      S_COMMIT: begin
        cmd.rate_commit = out_free;
        cmd.sum_add = out_free && started;
        cmd.out_load = out_free && started;
        cmd.out_what = WHAT_RATE;
        cmd.out_last = (ri == LAST_IDX) && !win_due;
      end
      S_WIN: begin
        cmd.sum_clear = out_free;
        cmd.out_load = out_free;
        cmd.out_what = WHAT_SUM;
        cmd.out_last = (ri == LAST_IDX);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start_ticks <= '0;
      window_ticks <= 32'd100;
      tick_count <= '0;
      window_count <= '0;
      started <= 1'b0;
      win_due <= 1'b0;
      ri <= '0;
      ci <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START: start_ticks <= cfg_data;
          REG_WINDOW: window_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && kind == KIND_TICK) begin
            started <= tick_count >= start_ticks;
            win_due <= window_count > window_ticks;
            ri <= '0;
            ci <= '0;
            state <= S_POP;
          end
        end
        S_POP: state <= S_PAIR;
        S_PAIR: state <= pair_on ? S_M1 : S_DONE;
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_NEXT;
        S_NEXT: state <= S_WAIT;
        S_WAIT: state <= S_ADD;
        S_ADD: state <= S_DONE;
        S_DONE: begin
          if (ci == LAST_IDX) begin
            ci <= '0;
            if (ri == LAST_IDX) begin
              ri <= '0;
              state <= S_COMMIT;
            end else begin
              ri <= ri + 1'b1;
              state <= S_POP;
            end
          end else begin
            ci <= ci + 1'b1;
            state <= S_PAIR;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            if (ri == LAST_IDX) begin
              ri <= '0;
              state <= win_due ? S_WIN : S_EMIT;
            end else ri <= ri + 1'b1;
          end
        end
        S_WIN: begin
          if (out_free) begin
            if (ri == LAST_IDX) begin
              ri <= '0;
              state <= S_EMIT;
            end else ri <= ri + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (win_due) window_count <= started ? 32'd1 : 32'd0;
            else if (started && window_count != 32'hFFFFFFFF)
              window_count <= window_count + 32'd1;
            if (tick_count != 32'hFFFFFFFF) tick_count <= tick_count + 32'd1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid);
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free);
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !out_valid);

endmodule

// ----- src/population_rate_network_step_core.sv -----
// Population rate network step core. Depends on prns_pkg, prns_ctrl and
// prns_datapath. Load items do not stall the input. A tick walks all sixteen
// pairs on one shared 33x33 multiplier: an enabled pair takes four products,
// each followed by its accumulate, plus the synaptic write-back and the
// weighted add, while a disabled pair is skipped; each population first
// loads its drive. Then each population commits its new rate (and transfers
// it once started), the window sums are transferred when a window closes,
// and a closing step ends the tick. The input is stalled for the whole
// tick, and a stall on the result side holds it longer.
module population_rate_network_step_core import prns_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [1:0] row,
  input  logic [1:0] col,
  input  logic signed [31:0] weight,
  input  logic [16:0] decay,
  input  logic [16:0] gain,
  input  logic [16:0] rk_factor,
  input  logic signed [31:0] syn_init,
  input  logic signed [31:0] drive,
  input  logic [30:0] rate_init,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic what,
  output logic [1:0] population,
  output logic [46:0] value,
  output logic last
);

  prns_cmd_t cmd;
  logic pair_on;
  logic [1:0] r_i, c_i;

  prns_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .kind,
    .row_in(row), .col_in(col), .cfg_we, .cfg_index, .cfg_data,
    .pair_on, .cmd, .row(r_i), .col(c_i), .out_valid, .out_stall
  );

  prns_datapath u_dp (
    .clk, .rst, .cmd, .row(r_i), .col(c_i), .weight, .decay, .gain,
    .rk_factor, .syn_init, .drive, .rate_init, .pair_on,
    .out_population(population), .out_what(what), .out_value(value),
    .out_last(last)
  );

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({what, population, value, last}));

endmodule
